/* src/assert_macros.svh */
// Assertion macros shared by the equalizer section RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/svfeq_pkg.sv */
// Shared types, constants and the micro-op schedule of the equalizer section.
package svfeq_pkg;

  localparam int COEFF_W             = 32;
  localparam int SAMPLE_W            = 16;
  localparam int CFG_IDX_W           = 3;
  localparam int COEFF_FRAC_BITS_DEF = 24;
  localparam int STATE_BITS_DEF      = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_A1        = 3'd0,
    REG_A2        = 3'd1,
    REG_A3        = 3'd2,
    REG_MIX_INPUT = 3'd3,
    REG_MIX_BAND  = 3'd4,
    REG_MIX_LOW   = 3'd5,
    REG_ENABLE    = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } seq_state_e;

  typedef enum logic [4:0] {
    STEP_V3, STEP_B1L, STEP_B1H, STEP_B2L, STEP_B2H, STEP_BDR, STEP_BRND,
    STEP_L1L, STEP_L1H, STEP_L2L, STEP_L2H, STEP_LDR, STEP_LRND,
    STEP_O0L, STEP_O0H, STEP_O1L, STEP_O1H, STEP_O2L, STEP_O2H, STEP_ODR, STEP_OUT
  } step_e;

  typedef enum logic [2:0] {
    COEF_A1, COEF_A2, COEF_A3, COEF_M0, COEF_M1, COEF_M2
  } coef_sel_e;

  typedef enum logic [2:0] {
    OPND_IC1, OPND_V3, OPND_V0, OPND_V1, OPND_V2
  } opnd_sel_e;

  typedef struct packed {
    logic mul_en;
    logic chunk_hi;
    logic clr;
    logic preset;
  } mac_ctrl_t;

  typedef struct packed {
    coef_sel_e coef_sel;
    opnd_sel_e opnd_sel;
    mac_ctrl_t mac;
    logic      ld_v3;
    logic      ld_v1;
    logic      ld_v2;
    logic      upd_ic1;
    logic      upd_ic2;
    logic      ld_out;
  } uop_t;

  function automatic int op_width(int frac_bits, int state_bits);
    op_width = (state_bits > SAMPLE_W + frac_bits) ? state_bits : SAMPLE_W + frac_bits;
  endfunction

  function automatic uop_t mul_uop(coef_sel_e c, opnd_sel_e o, logic hi);
    uop_t u;
    u = '0;
    u.coef_sel       = c;
    u.opnd_sel       = o;
    u.mac.mul_en     = 1'b1;
    u.mac.chunk_hi   = hi;
    mul_uop = u;
  endfunction

  function automatic uop_t uop_decode(step_e s);
    uop_t u;
    u = '0;
    case (s)
      STEP_V3:   begin
        u.ld_v3   = 1'b1;
        u.mac.clr = 1'b1;
      end
      STEP_B1L:  u = mul_uop(COEF_A1, OPND_IC1, 1'b0);
      STEP_B1H:  u = mul_uop(COEF_A1, OPND_IC1, 1'b1);
      STEP_B2L:  u = mul_uop(COEF_A2, OPND_V3, 1'b0);
      STEP_B2H:  u = mul_uop(COEF_A2, OPND_V3, 1'b1);
      STEP_BRND: begin
        u.ld_v1      = 1'b1;
        u.mac.preset = 1'b1;
      end
      STEP_L1L:  u = mul_uop(COEF_A2, OPND_IC1, 1'b0);
      STEP_L1H:  u = mul_uop(COEF_A2, OPND_IC1, 1'b1);
      STEP_L2L:  u = mul_uop(COEF_A3, OPND_V3, 1'b0);
      STEP_L2H:  u = mul_uop(COEF_A3, OPND_V3, 1'b1);
      STEP_LRND: begin
        u.ld_v2   = 1'b1;
        u.upd_ic1 = 1'b1;
        u.mac.clr = 1'b1;
      end
      STEP_O0L:  begin
        u = mul_uop(COEF_M0, OPND_V0, 1'b0);
        u.upd_ic2 = 1'b1;
      end
      STEP_O0H:  u = mul_uop(COEF_M0, OPND_V0, 1'b1);
      STEP_O1L:  u = mul_uop(COEF_M1, OPND_V1, 1'b0);
      STEP_O1H:  u = mul_uop(COEF_M1, OPND_V1, 1'b1);
      STEP_O2L:  u = mul_uop(COEF_M2, OPND_V2, 1'b0);
      STEP_O2H:  u = mul_uop(COEF_M2, OPND_V2, 1'b1);
      STEP_OUT:  u.ld_out = 1'b1;
      default:   u = '0;
    endcase
    uop_decode = u;
  endfunction

endpackage

/* src/svfeq_mac.sv */
// Shared multiply-accumulate unit with round-and-saturate of the accumulator.
`include "assert_macros.svh"

module svfeq_mac #(
  parameter int COEFF_FRAC_BITS = svfeq_pkg::COEFF_FRAC_BITS_DEF,
  parameter int STATE_BITS      = svfeq_pkg::STATE_BITS_DEF,
  parameter int OP_W            = svfeq_pkg::op_width(COEFF_FRAC_BITS, STATE_BITS)
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  svfeq_pkg::mac_ctrl_t                    ctrl_i,
  input  logic signed [svfeq_pkg::COEFF_W-1:0]    coef_i,
  input  logic signed [OP_W-1:0]                  opnd_i,
  input  logic signed [STATE_BITS-1:0]            preset_i,
  output logic signed [STATE_BITS-1:0]            rnd_state_o,
  output logic signed [svfeq_pkg::SAMPLE_W-1:0]   rnd_out_o
);

  localparam int LO_W    = (OP_W + 1) / 2;
  localparam int MUL_B_W = LO_W + 1;
  localparam int PROD_W  = svfeq_pkg::COEFF_W + MUL_B_W;
  localparam int ACC_W   = svfeq_pkg::COEFF_W + OP_W + 2;
  localparam int RND_W   = ACC_W + 1;

  localparam logic signed [RND_W-1:0] HALF_ST = RND_W'(1) <<< (COEFF_FRAC_BITS - 1);
  localparam logic signed [RND_W-1:0] HALF_OUT = RND_W'(1) <<< (2 * COEFF_FRAC_BITS - 1);
  localparam logic signed [RND_W-1:0] ST_MAX = (RND_W'(1) <<< (STATE_BITS - 1)) - RND_W'(1);
  localparam logic signed [RND_W-1:0] ST_MIN = -ST_MAX - RND_W'(1);
  localparam logic signed [RND_W-1:0] OUT_MAX =
    (RND_W'(1) <<< (svfeq_pkg::SAMPLE_W - 1)) - RND_W'(1);
  localparam logic signed [RND_W-1:0] OUT_MIN = -OUT_MAX - RND_W'(1);

  logic signed [MUL_B_W-1:0] chunk;
  logic signed [PROD_W-1:0]  prod_d, prod_q;
  logic                      prod_vld_q, prod_hi_q;
  logic signed [ACC_W-1:0]   term, acc_d, acc_q;
  logic signed [RND_W-1:0]   rs_st, rs_out, st_sat, out_sat;

  assign chunk = ctrl_i.chunk_hi ? MUL_B_W'(signed'(opnd_i[OP_W-1:LO_W]))
                                 : signed'({1'b0, opnd_i[LO_W-1:0]});
  assign prod_d = coef_i * chunk;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
      prod_hi_q  <= 1'b0;
    end else begin
      prod_vld_q <= ctrl_i.mul_en;
      prod_hi_q  <= ctrl_i.chunk_hi;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
    acc_q <= acc_d;
  end

  assign term = prod_hi_q ? (ACC_W'(prod_q) <<< LO_W) : ACC_W'(prod_q);

  always_comb begin
    if (ctrl_i.clr) begin
      acc_d = '0;
    end else if (ctrl_i.preset) begin
      acc_d = ACC_W'(preset_i) <<< COEFF_FRAC_BITS;
    end else if (prod_vld_q) begin
      acc_d = acc_q + term;
    end else begin
      acc_d = acc_q;
    end
  end

  assign rs_st  = (RND_W'(acc_q) + HALF_ST) >>> COEFF_FRAC_BITS;
  assign rs_out = (RND_W'(acc_q) + HALF_OUT) >>> (2 * COEFF_FRAC_BITS);

  assign st_sat  = (rs_st > ST_MAX) ? ST_MAX : ((rs_st < ST_MIN) ? ST_MIN : rs_st);
  assign out_sat = (rs_out > OUT_MAX) ? OUT_MAX : ((rs_out < OUT_MIN) ? OUT_MIN : rs_out);

  assign rnd_state_o = st_sat[STATE_BITS-1:0];
  assign rnd_out_o   = out_sat[svfeq_pkg::SAMPLE_W-1:0];

  `ASSERT_IMPLY(a_no_lost_product, clk_i, rst_ni, ctrl_i.clr || ctrl_i.preset, !prod_vld_q)
  `ASSERT_NEXT(a_hi_follows_lo, clk_i, rst_ni, ctrl_i.mul_en && ctrl_i.chunk_hi, prod_vld_q && prod_hi_q)

endmodule

/* src/svf_equalizer_section_unit.sv */
// Top level of the trapezoidal state-variable filter equalizer section.
`include "assert_macros.svh"

// One filter section of an equalizer. A filtered word holds the block from acceptance
// until its result is loaded into the output register; no new word is accepted meanwhile.
// The schedule is set by the single shared 32 x 21 multiplier, which forms each of the
// seven products in two halves, plus one step for the input difference and one drain
// and one round step per result. While the stage enable is 0 a word passes straight
// to the output register, and one word can be accepted every cycle unless the output
// stalls. The output register lets the next word in while a finished word still waits.
module svf_equalizer_section_unit #(
  parameter int COEFF_FRAC_BITS = svfeq_pkg::COEFF_FRAC_BITS_DEF,
  parameter int STATE_BITS      = svfeq_pkg::STATE_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [svfeq_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [svfeq_pkg::COEFF_W-1:0]          cfg_wdata_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [svfeq_pkg::SAMPLE_W-1:0]  sample_in_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [svfeq_pkg::SAMPLE_W-1:0]  sample_out_o
);

  localparam int OP_W = svfeq_pkg::op_width(COEFF_FRAC_BITS, STATE_BITS);
  localparam int W2   = OP_W + 2;
  localparam int CW   = svfeq_pkg::COEFF_W;

  localparam logic signed [CW-1:0] UNITY = CW'(1) <<< COEFF_FRAC_BITS;
  localparam logic signed [W2-1:0] ST_MAX = (W2'(1) <<< (STATE_BITS - 1)) - W2'(1);
  localparam logic signed [W2-1:0] ST_MIN = -ST_MAX - W2'(1);

  function automatic logic signed [STATE_BITS-1:0] sat_state(input logic signed [W2-1:0] v);
    logic signed [W2-1:0] c;
    c = (v > ST_MAX) ? ST_MAX : ((v < ST_MIN) ? ST_MIN : v);
    sat_state = c[STATE_BITS-1:0];
  endfunction

  svfeq_pkg::seq_state_e state_q;
  svfeq_pkg::step_e      step_q;
  svfeq_pkg::uop_t       uop;
  svfeq_pkg::mac_ctrl_t  mac_ctrl;

  logic signed [CW-1:0] a1_q, a2_q, a3_q, m0_q, m1_q, m2_q, coef;
  logic                 en_q;
  logic signed [STATE_BITS-1:0] ic1_q, ic2_q, v1_q, v2_q, v3_q, rnd_state;
  logic signed [svfeq_pkg::SAMPLE_W-1:0] x_q, out_q, rnd_out;
  logic                 out_valid_q;
  logic signed [OP_W-1:0] v0, opnd;
  logic                 run, in_acc, out_free, out_hold;

  assign run      = (state_q == svfeq_pkg::ST_RUN);
  assign uop      = svfeq_pkg::uop_decode(step_q);
  assign mac_ctrl = run ? uop.mac : '0;
  assign out_free = !(out_valid_q && out_stall_i);
  assign out_hold = run && uop.ld_out && !out_free;

  assign in_stall_o = (state_q != svfeq_pkg::ST_IDLE) || (!en_q && !out_free);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign v0 = OP_W'(x_q) <<< COEFF_FRAC_BITS;

  always_comb begin
    case (uop.coef_sel)
      svfeq_pkg::COEF_A1: coef = a1_q;
      svfeq_pkg::COEF_A2: coef = a2_q;
      svfeq_pkg::COEF_A3: coef = a3_q;
      svfeq_pkg::COEF_M0: coef = m0_q;
      svfeq_pkg::COEF_M1: coef = m1_q;
      svfeq_pkg::COEF_M2: coef = m2_q;
      default:            coef = '0;
    endcase
  end

  always_comb begin
    case (uop.opnd_sel)
      svfeq_pkg::OPND_IC1: opnd = OP_W'(ic1_q);
      svfeq_pkg::OPND_V3:  opnd = OP_W'(v3_q);
      svfeq_pkg::OPND_V0:  opnd = v0;
      svfeq_pkg::OPND_V1:  opnd = OP_W'(v1_q);
      svfeq_pkg::OPND_V2:  opnd = OP_W'(v2_q);
      default:             opnd = '0;
    endcase
  end

  svfeq_mac #(
    .COEFF_FRAC_BITS (COEFF_FRAC_BITS),
    .STATE_BITS      (STATE_BITS),
    .OP_W            (OP_W)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (mac_ctrl),
    .coef_i      (coef),
    .opnd_i      (opnd),
    .preset_i    (ic2_q),
    .rnd_state_o (rnd_state),
    .rnd_out_o   (rnd_out)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a1_q        <= '0;
      a2_q        <= '0;
      a3_q        <= '0;
      m0_q        <= UNITY;
      m1_q        <= '0;
      m2_q        <= '0;
      en_q        <= 1'b0;
      state_q     <= svfeq_pkg::ST_IDLE;
      step_q      <= svfeq_pkg::STEP_V3;
      out_valid_q <= 1'b0;
      ic1_q       <= '0;
      ic2_q       <= '0;
    end else begin
      if (cfg_we_i) begin
        case (svfeq_pkg::cfg_idx_e'(cfg_idx_i))
          svfeq_pkg::REG_A1:        a1_q <= signed'(cfg_wdata_i);
          svfeq_pkg::REG_A2:        a2_q <= signed'(cfg_wdata_i);
          svfeq_pkg::REG_A3:        a3_q <= signed'(cfg_wdata_i);
          svfeq_pkg::REG_MIX_INPUT: m0_q <= signed'(cfg_wdata_i);
          svfeq_pkg::REG_MIX_BAND:  m1_q <= signed'(cfg_wdata_i);
          svfeq_pkg::REG_MIX_LOW:   m2_q <= signed'(cfg_wdata_i);
          svfeq_pkg::REG_ENABLE:    en_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end

      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (in_acc) begin
        if (en_q) begin
          state_q <= svfeq_pkg::ST_RUN;
          step_q  <= svfeq_pkg::STEP_V3;
        end else begin
          ic1_q       <= '0;
          ic2_q       <= '0;
          out_valid_q <= 1'b1;
        end
      end

      if (run) begin
        if (uop.upd_ic1) begin
          ic1_q <= sat_state((W2'(v1_q) <<< 1) - W2'(ic1_q));
        end
        if (uop.upd_ic2) begin
          ic2_q <= sat_state((W2'(v2_q) <<< 1) - W2'(ic2_q));
        end
        if (uop.ld_out) begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            state_q     <= svfeq_pkg::ST_IDLE;
            step_q      <= svfeq_pkg::STEP_V3;
          end
        end else begin
          step_q <= svfeq_pkg::step_e'(step_q + 5'd1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q <= sample_in_i;
      if (!en_q) begin
        out_q <= sample_in_i;
      end
    end
    if (run) begin
      if (uop.ld_v3) begin
        v3_q <= sat_state(W2'(v0) - W2'(ic2_q));
      end
      if (uop.ld_v1) begin
        v1_q <= rnd_state;
      end
      if (uop.ld_v2) begin
        v2_q <= rnd_state;
      end
      if (uop.ld_out && out_free) begin
        out_q <= rnd_out;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign sample_out_o = out_q;

  `ASSERT_IMPLY(a_accept_when_idle, clk_i, rst_ni, in_acc, state_q == svfeq_pkg::ST_IDLE)
  `ASSERT_NEXT(a_bypass_clears, clk_i, rst_ni, in_acc && !en_q, out_valid_q && ic1_q == '0 && ic2_q == '0)
  `ASSERT_NEXT(a_final_hold, clk_i, rst_ni, out_hold, run && step_q == svfeq_pkg::STEP_OUT)

endmodule
